// ----- hw/rtl/arrc_pkg.sv -----
// Shared types, constants and helpers for the actuator ramp reverse controller.
package arrc_pkg;

   localparam int DUTY_BITS = 10;
   localparam int BTN_BITS  = 8;
   localparam int CSR_BITS  = 2;

   // Button bit positions
   localparam int BTN_EXTEND  = 4;
   localparam int BTN_POWER   = 5;
   localparam int BTN_RETRACT = 7;

   localparam logic [DUTY_BITS-1:0] RESET_STEP  = DUTY_BITS'(100);
   localparam logic [DUTY_BITS-1:0] RESET_LIMIT = DUTY_BITS'(400);
   localparam logic [DUTY_BITS-1:0] RESET_START = DUTY_BITS'(100);

   typedef enum logic [CSR_BITS-1:0] {
      CSR_RAMP_STEP  = 2'd0,
      CSR_DUTY_LIMIT = 2'd1,
      CSR_START_DUTY = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_STOPPED = 2'd0,
      MODE_RETRACT = 2'd1,
      MODE_EXTEND  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [BTN_BITS-1:0] button_byte;
      logic                end_stop_high_switch;
      logic                end_stop_low_switch;
   } req_payload_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] extend_duty;
      logic [DUTY_BITS-1:0] retract_duty;
      logic [1:0]           mode_now;
      logic                 power_enabled;
   } rsp_payload_type;

   // Grow a ramp by one step, saturating at the limit.
   function automatic logic [DUTY_BITS-1:0] ramp_advance(
      input logic [DUTY_BITS-1:0] ramp,
      input logic [DUTY_BITS-1:0] step,
      input logic [DUTY_BITS-1:0] limit
   );
      logic [DUTY_BITS:0] sum;
      logic [DUTY_BITS-1:0] result;
      sum = {1'b0, ramp} + {1'b0, step};
      if (ramp < limit && sum <= {1'b0, limit}) begin
         result = sum[DUTY_BITS-1:0];
      end else begin
         result = limit;
      end
      return result;
   endfunction

   // Let the brake level fall by one step, clamped at zero.
   function automatic logic [DUTY_BITS-1:0] brake_fall(
      input logic [DUTY_BITS-1:0] level,
      input logic [DUTY_BITS-1:0] step
   );
      logic [DUTY_BITS-1:0] result;
      if (level > step) begin
         result = level - step;
      end else begin
         result = '0;
      end
      return result;
   endfunction

endpackage

// ----- hw/rtl/actuator_ramp_reverse_controller.sv -----
// Top level of the actuator ramp reverse controller: button decode and one control step per beat.
module actuator_ramp_reverse_controller
   import arrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_BITS-1:0]   csr_index,
   input  logic [DUTY_BITS-1:0]  csr_data
);

   // Each request beat is one control tick. The whole tick (edge decode, brake
   // load, ramp or brake update) is evaluated combinationally against the state
   // registers, and its result is captured in a single output register, so the
   // response appears in the cycle after acceptance. A new beat is taken every
   // cycle; the input stalls only while the output register holds a response
   // that is itself stalled.

   logic [DUTY_BITS-1:0] ramp_step_ff, duty_limit_ff, start_duty_ff;

   logic [BTN_BITS-1:0]  prev_buttons_ff, prev_buttons_in;
   mode_type             dir_mode_ff, dir_mode_in;
   mode_type             prev_mode_ff, prev_mode_in;
   mode_type             resume_dir_ff, resume_dir_in;
   logic                 power_ff, power_in;
   logic [DUTY_BITS-1:0] extend_ramp_ff, extend_ramp_in;
   logic [DUTY_BITS-1:0] retract_ramp_ff, retract_ramp_in;
   logic [DUTY_BITS-1:0] brake_ff, brake_in;
   logic [DUTY_BITS-1:0] extend_hold_ff, extend_hold_in;
   logic [DUTY_BITS-1:0] retract_hold_ff, retract_hold_in;

   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_payload_ff;

   logic                 req_take;
   logic [BTN_BITS-1:0]  rise;
   mode_type             mode_sel;
   logic [DUTY_BITS-1:0] brake_sel;
   logic [DUTY_BITS-1:0] drive_ramp;
   logic                 stop_hi, stop_lo;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff  <= RESET_STEP;
         duty_limit_ff <= RESET_LIMIT;
         start_duty_ff <= RESET_START;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RAMP_STEP:  ramp_step_ff  <= csr_data;
            CSR_DUTY_LIMIT: duty_limit_ff <= csr_data;
            CSR_START_DUTY: start_duty_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // One control tick
   always_comb begin
      stop_hi = req_payload.end_stop_high_switch;
      stop_lo = !stop_hi && req_payload.end_stop_low_switch;
      rise    = req_payload.button_byte & ~prev_buttons_ff;

      mode_sel = dir_mode_ff;
      if (rise[BTN_EXTEND]) begin
         mode_sel = MODE_EXTEND;
      end
      if (rise[BTN_RETRACT]) begin
         mode_sel = MODE_RETRACT;
      end
      power_in        = power_ff ^ rise[BTN_POWER];
      prev_buttons_in = req_payload.button_byte;

      // Load the old ramp as brake level on a reversal
      brake_sel = brake_ff;
      if (prev_mode_ff != mode_sel && prev_mode_ff != MODE_STOPPED &&
          mode_sel != MODE_STOPPED) begin
         if (prev_mode_ff == MODE_RETRACT) begin
            brake_sel = retract_ramp_ff;
         end else if (prev_mode_ff == MODE_EXTEND) begin
            brake_sel = extend_ramp_ff;
         end
      end
      prev_mode_in = mode_sel;

      dir_mode_in     = mode_sel;
      resume_dir_in   = resume_dir_ff;
      brake_in        = brake_sel;
      extend_ramp_in  = extend_ramp_ff;
      retract_ramp_in = retract_ramp_ff;
      extend_hold_in  = extend_hold_ff;
      retract_hold_in = retract_hold_ff;
      drive_ramp      = '0;

      if (power_in) begin
         case (mode_sel)
            MODE_RETRACT: begin
               extend_ramp_in = start_duty_ff;
               resume_dir_in  = MODE_RETRACT;
               if (brake_sel != '0) begin
                  extend_hold_in  = brake_sel;
                  retract_hold_in = '0;
                  brake_in        = brake_fall(brake_sel, ramp_step_ff);
               end else begin
                  drive_ramp      = stop_lo ? '0 : retract_ramp_ff;
                  retract_hold_in = drive_ramp;
                  extend_hold_in  = '0;
                  retract_ramp_in = ramp_advance(drive_ramp, ramp_step_ff, duty_limit_ff);
               end
            end
            MODE_EXTEND: begin
               retract_ramp_in = start_duty_ff;
               resume_dir_in   = MODE_EXTEND;
               if (brake_sel != '0) begin
                  retract_hold_in = brake_sel;
                  extend_hold_in  = '0;
                  brake_in        = brake_fall(brake_sel, ramp_step_ff);
               end else begin
                  drive_ramp      = stop_hi ? '0 : extend_ramp_ff;
                  extend_hold_in  = drive_ramp;
                  retract_hold_in = '0;
                  extend_ramp_in  = ramp_advance(drive_ramp, ramp_step_ff, duty_limit_ff);
               end
            end
            default: begin
               // No direction: resume the last one, duties hold
               dir_mode_in = resume_dir_ff;
            end
         endcase
      end else begin
         dir_mode_in     = MODE_STOPPED;
         extend_hold_in  = '0;
         retract_hold_in = '0;
         extend_ramp_in  = start_duty_ff;
         retract_ramp_in = start_duty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= '0;
         dir_mode_ff     <= MODE_STOPPED;
         prev_mode_ff    <= MODE_STOPPED;
         resume_dir_ff   <= MODE_EXTEND;
         power_ff        <= 1'b0;
         extend_ramp_ff  <= RESET_START;
         retract_ramp_ff <= RESET_START;
         brake_ff        <= '0;
         extend_hold_ff  <= '0;
         retract_hold_ff <= '0;
      end else if (req_take) begin
         prev_buttons_ff <= prev_buttons_in;
         dir_mode_ff     <= dir_mode_in;
         prev_mode_ff    <= prev_mode_in;
         resume_dir_ff   <= resume_dir_in;
         power_ff        <= power_in;
         extend_ramp_ff  <= extend_ramp_in;
         retract_ramp_ff <= retract_ramp_in;
         brake_ff        <= brake_in;
         extend_hold_ff  <= extend_hold_in;
         retract_hold_ff <= retract_hold_in;
      end
   end

   // Output register: load on every accepted beat, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_payload_ff.extend_duty   <= extend_hold_in;
         rsp_payload_ff.retract_duty  <= retract_hold_in;
         rsp_payload_ff.mode_now      <= dir_mode_in;
         rsp_payload_ff.power_enabled <= power_in;
      end
   end

   a_power_off_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.power_enabled |->
         rsp_payload.extend_duty == '0 && rsp_payload.retract_duty == '0 &&
         rsp_payload.mode_now == MODE_STOPPED)
      else $error("power off response with nonzero duty or active mode");

   a_one_leg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.extend_duty == '0 || rsp_payload.retract_duty == '0)
      else $error("both bridge legs driven");

   a_power_on_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.power_enabled |->
         rsp_payload.mode_now == MODE_RETRACT || rsp_payload.mode_now == MODE_EXTEND)
      else $error("power on response without a direction");

   a_take_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("accepted beat produced no response");

endmodule

// ----- tb/tb_actuator_ramp_reverse_controller.sv -----
// Self-checking testbench for the actuator ramp reverse controller.
module tb_actuator_ramp_reverse_controller;
   import arrc_pkg::*;

   localparam int CLOCK_HALF       = 4;
   localparam int RESET_CYCLES     = 7;
   localparam int DRAIN_CYCLES     = 16;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int RANDOM_PER_PHASE = 205;
   localparam int RUN_LIMIT        = 2_000_000;

   localparam logic [CSR_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam logic [BTN_BITS-1:0] PRESS_EXTEND  = BTN_BITS'(1 << BTN_EXTEND);
   localparam logic [BTN_BITS-1:0] PRESS_POWER   = BTN_BITS'(1 << BTN_POWER);
   localparam logic [BTN_BITS-1:0] PRESS_RETRACT = BTN_BITS'(1 << BTN_RETRACT);
   localparam logic [BTN_BITS-1:0] NO_BUTTONS    = '0;
   localparam logic [BTN_BITS-1:0] ALL_BUTTONS   = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_payload_type      rsp_payload;
   logic                 csr_write;
   logic [CSR_BITS-1:0]  csr_index;
   logic [DUTY_BITS-1:0] csr_data;

   actuator_ramp_reverse_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Controller state as predicted
   logic [DUTY_BITS-1:0] cfg_step, cfg_limit, cfg_start;
   logic [BTN_BITS-1:0]  prev_buttons;
   mode_type             dir_mode, last_mode, resume_mode;
   logic                 power_on;
   logic [DUTY_BITS-1:0] ext_ramp, ret_ramp, brake, ext_hold, ret_hold;

   req_payload_type pending_beats[$];
   rsp_payload_type expected_rsps[$];
   logic [BTN_BITS-1:0] last_queued_byte;

   int  req_offered, req_taken, rsp_taken;
   int  error_count, setting_count;
   int  long_holds_asked, long_holds_started;
   bit  calm_phase;

   always #CLOCK_HALF clock = ~clock;

   function automatic logic [DUTY_BITS-1:0] ramp_grow(input logic [DUTY_BITS-1:0] ramp);
      logic [DUTY_BITS:0] sum;
      sum = {1'b0, ramp} + {1'b0, cfg_step};
      if (ramp >= cfg_limit || sum > {1'b0, cfg_limit}) return cfg_limit;
      return sum[DUTY_BITS-1:0];
   endfunction

   function automatic rsp_payload_type controller_tick(input req_payload_type beat);
      rsp_payload_type      result;
      logic [BTN_BITS-1:0]  rising;
      logic                 hi_stop, lo_stop;
      rising  = beat.button_byte & ~prev_buttons;
      hi_stop = beat.end_stop_high_switch;
      lo_stop = !hi_stop && beat.end_stop_low_switch;
      // retract is decoded last so it wins over a simultaneous extend
      if (rising[BTN_EXTEND]) dir_mode = MODE_EXTEND;
      if (rising[BTN_POWER]) power_on = !power_on;
      if (rising[BTN_RETRACT]) dir_mode = MODE_RETRACT;
      prev_buttons = beat.button_byte;
      if (last_mode != dir_mode && last_mode != MODE_STOPPED && dir_mode != MODE_STOPPED) begin
         brake = (last_mode == MODE_RETRACT) ? ret_ramp : ext_ramp;
      end
      last_mode = dir_mode;
      if (power_on) begin
         case (dir_mode)
            MODE_RETRACT: begin
               ext_ramp    = cfg_start;
               resume_mode = MODE_RETRACT;
               if (brake != '0) begin
                  ext_hold = brake;
                  ret_hold = '0;
                  brake    = (brake > cfg_step) ? brake - cfg_step : '0;
               end else begin
                  if (lo_stop) ret_ramp = '0;
                  ret_hold = ret_ramp;
                  ext_hold = '0;
                  ret_ramp = ramp_grow(ret_ramp);
               end
            end
            MODE_EXTEND: begin
               ret_ramp    = cfg_start;
               resume_mode = MODE_EXTEND;
               if (brake != '0) begin
                  ret_hold = brake;
                  ext_hold = '0;
                  brake    = (brake > cfg_step) ? brake - cfg_step : '0;
               end else begin
                  if (hi_stop) ext_ramp = '0;
                  ext_hold = ext_ramp;
                  ret_hold = '0;
                  ext_ramp = ramp_grow(ext_ramp);
               end
            end
            default: dir_mode = resume_mode;
         endcase
      end else begin
         dir_mode = MODE_STOPPED;
         ext_hold = '0;
         ret_hold = '0;
         ext_ramp = cfg_start;
         ret_ramp = cfg_start;
      end
      result.extend_duty   = ext_hold;
      result.retract_duty  = ret_hold;
      result.mode_now      = dir_mode;
      result.power_enabled = power_on;
      return result;
   endfunction

   // Sender: one beat in flight, random gap before each new one
   always @(negedge clock) begin
      int gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_taken == req_offered) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            req_payload <= pending_beats.pop_front();
            req_valid   <= 1'b1;
            req_offered++;
            gap_left = calm_phase ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall after each beat, plus the occasional long hold
   always @(negedge clock) begin
      int stall_left, hold_left, rsp_seen;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         rsp_seen   = 0;
      end else begin
         if (long_holds_started != long_holds_asked) begin
            long_holds_started++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_seen != rsp_taken) begin
            rsp_seen   = rsp_taken;
            stall_left = calm_phase ? 0 : $urandom_range(0, 6);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_RAMP_STEP:  cfg_step  = csr_data;
               CSR_DUTY_LIMIT: cfg_limit = csr_data;
               CSR_START_DUTY: cfg_start = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(controller_tick(req_payload));
            req_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken++;
            if (expected_rsps.size() == 0) begin
               $error("response beat with nothing expected");
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.extend_duty !== want.extend_duty) begin
                  $error("extend_duty: expected %0d, actual %0d",
                         want.extend_duty, rsp_payload.extend_duty);
                  error_count++;
               end
               if (rsp_payload.retract_duty !== want.retract_duty) begin
                  $error("retract_duty: expected %0d, actual %0d",
                         want.retract_duty, rsp_payload.retract_duty);
                  error_count++;
               end
               if (rsp_payload.mode_now !== want.mode_now) begin
                  $error("mode_now: expected %0d, actual %0d",
                         want.mode_now, rsp_payload.mode_now);
                  error_count++;
               end
               if (rsp_payload.power_enabled !== want.power_enabled) begin
                  $error("power_enabled: expected %0d, actual %0d",
                         want.power_enabled, rsp_payload.power_enabled);
                  error_count++;
               end
            end
         end
      end
   end

   function automatic void queue_beat(input logic [BTN_BITS-1:0] buttons,
                                      input logic hi, input logic lo);
      req_payload_type beat;
      beat.button_byte          = buttons;
      beat.end_stop_high_switch = hi;
      beat.end_stop_low_switch  = lo;
      pending_beats.push_back(beat);
      last_queued_byte = buttons;
   endfunction

   // Mostly deliberate presses with random noise bits, some held, some pure noise
   function automatic void queue_random_beat();
      logic [BTN_BITS-1:0] buttons;
      int                  roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         buttons = BTN_BITS'($urandom);
      end else if (roll < 38) begin
         buttons = last_queued_byte;
      end else begin
         buttons = BTN_BITS'($urandom) & ~(PRESS_EXTEND | PRESS_POWER | PRESS_RETRACT);
         if ($urandom_range(0, 99) < 7) buttons |= PRESS_EXTEND;
         if ($urandom_range(0, 99) < 7) buttons |= PRESS_RETRACT;
         if ($urandom_range(0, 99) < 2) buttons |= PRESS_POWER;
      end
      queue_beat(buttons, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
   endfunction

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_taken != req_offered ||
             expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_BITS-1:0] index, input logic [DUTY_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [DUTY_BITS-1:0] step, input logic [DUTY_BITS-1:0] limit,
                            input logic [DUTY_BITS-1:0] start, input bit calm,
                            input bit long_hold);
      wait_idle();
      write_csr(CSR_RAMP_STEP, step);
      write_csr(CSR_DUTY_LIMIT, limit);
      write_csr(CSR_START_DUTY, start);
      // index with no register behind it: must be dropped
      write_csr(CSR_UNUSED, DUTY_BITS'($urandom));
      @(negedge clock);
      csr_write <= 1'b0;
      setting_count++;
      calm_phase = calm;
      if (long_hold) long_holds_asked++;
      repeat (RANDOM_PER_PHASE) queue_random_beat();
   endtask

   initial begin
      #RUN_LIMIT;
      $display("Verification failed");
      $finish;
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      cfg_step     = RESET_STEP;
      cfg_limit    = RESET_LIMIT;
      cfg_start    = RESET_START;
      prev_buttons = '0;
      dir_mode     = MODE_STOPPED;
      last_mode    = MODE_STOPPED;
      resume_mode  = MODE_EXTEND;
      power_on     = 1'b0;
      ext_ramp     = RESET_START;
      ret_ramp     = RESET_START;
      brake        = '0;
      ext_hold     = '0;
      ret_hold     = '0;
      last_queued_byte = '0;
      calm_phase   = 1'b0;
      setting_count = 1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk at the reset settings
      queue_beat(NO_BUTTONS, 1'b0, 1'b0);
      queue_beat(PRESS_POWER, 1'b0, 1'b0);
      queue_beat(NO_BUTTONS, 1'b0, 1'b0);
      queue_beat(PRESS_EXTEND, 1'b0, 1'b0);
      queue_beat(PRESS_EXTEND, 1'b0, 1'b0);
      repeat (3) queue_beat(NO_BUTTONS, 1'b0, 1'b0);
      // reversal into retract: brake the extend leg down first
      queue_beat(PRESS_RETRACT, 1'b0, 1'b0);
      repeat (5) queue_beat(NO_BUTTONS, 1'b0, 1'b0);
      queue_beat(PRESS_RETRACT | PRESS_EXTEND, 1'b0, 1'b0);
      queue_beat(NO_BUTTONS, 1'b0, 1'b1);
      queue_beat(NO_BUTTONS, 1'b1, 1'b1);
      queue_beat(PRESS_EXTEND, 1'b1, 1'b0);
      repeat (3) queue_beat(NO_BUTTONS, 1'b1, 1'b0);
      queue_beat(ALL_BUTTONS, 1'b0, 1'b0);
      queue_beat(NO_BUTTONS, 1'b0, 1'b0);
      queue_beat(PRESS_POWER, 1'b1, 1'b1);

      run_phase(RESET_STEP, RESET_LIMIT, RESET_START, 1'b0, 1'b0);
      run_phase('1, '1, '0, 1'b1, 1'b1);
      run_phase('0, '0, '1, 1'b0, 1'b0);
      run_phase(DUTY_BITS'(1), '1, '1, 1'b0, 1'b0);
      run_phase(DUTY_BITS'(7), DUTY_BITS'(300), DUTY_BITS'(900), 1'b1, 1'b0);
      for (int phase = 0; phase < 4; phase++) begin
         run_phase(DUTY_BITS'($urandom_range(0, 1023) >> $urandom_range(0, 9)),
                   DUTY_BITS'($urandom), DUTY_BITS'($urandom), phase[0], phase == 2);
      end
      wait_idle();

      $display("Covered %0d request beats and %0d response beats across %0d register settings,",
               req_taken, rsp_taken, setting_count);
      $display("including reversals, end stops, power toggles and a long response hold.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- actuator_ramp_reverse_controller.f -----
hw/rtl/arrc_pkg.sv
hw/rtl/actuator_ramp_reverse_controller.sv
tb/tb_actuator_ramp_reverse_controller.sv
